// ===== rtl/core/ioc_pkg.sv =====
// Package for the in-order completion ring: kind codes, operation classes,
// the item struct passed from the front queue to the back engine, and the result struct.
// No dependencies.
`default_nettype none

package ioc_pkg;

  // Kind codes on the command port.
  localparam logic [1:0] KIND_ADD     = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_CONSUME = 2'd2;
  localparam logic [1:0] KIND_NOP     = 2'd3;

  localparam int unsigned PTR_W   = 63;
  localparam int unsigned SLOT_W  = 8;
  localparam int unsigned COUNT_W = 9;

  // Operation class decided by the front end.
  typedef enum logic [1:0] {
    OP_NOP,
    OP_ADD,
    OP_RELEASE,
    OP_CONSUME
  } ioc_op_e;

  // Back engine states.
  typedef enum logic {
    BK_IDLE,
    BK_WALK
  } ioc_back_state_e;

  // One queued item.
  typedef struct packed {
    ioc_op_e            op;
    logic [PTR_W-1:0]   end_pointer;
    logic [SLOT_W-1:0]  slot;
  } ioc_cmd_t;

  // One result item.
  typedef struct packed {
    logic               status;
    logic [SLOT_W-1:0]  slot_index;
    logic               retired_any;
    logic [PTR_W-1:0]   max_pointer;
    logic [COUNT_W-1:0] retired_count;
  } ioc_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/ioc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module ioc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/core/ioc_front.sv =====
// Front end: accepts items, classifies them and holds them in a two-entry
// queue for the back engine. Depends on ioc_pkg.
`default_nettype none

module ioc_front #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   kind_i,
  input  logic [ioc_pkg::PTR_W-1:0]    end_pointer_i,
  input  logic [ioc_pkg::SLOT_W-1:0]   slot_i,
  output logic                         cmd_valid_o,
  output ioc_pkg::ioc_cmd_t            cmd_o,
  input  logic                         cmd_pop_i
);

  ioc_pkg::ioc_cmd_t cmd_in;
  ioc_pkg::ioc_cmd_t q_mem_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        fill_q;
  logic [31:0]       slot_w;
  logic              push;

  assign slot_w = 32'(slot_i);

  // Classify the incoming item; a release beyond the ring does nothing.
  always_comb begin
    cmd_in.end_pointer = end_pointer_i;
    cmd_in.slot        = slot_i;
    unique case (kind_i)
      ioc_pkg::KIND_ADD:     cmd_in.op = ioc_pkg::OP_ADD;
      ioc_pkg::KIND_RELEASE: cmd_in.op = (slot_w < 32'(DEPTH)) ? ioc_pkg::OP_RELEASE
                                                                : ioc_pkg::OP_NOP;
      ioc_pkg::KIND_CONSUME: cmd_in.op = ioc_pkg::OP_CONSUME;
      default:               cmd_in.op = ioc_pkg::OP_NOP;
    endcase
  end

  assign busy        = (fill_q == 2'd2);
  assign push        = start && !busy;
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = q_mem_q[rd_ptr_q];

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cmd_in;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (cmd_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      fill_q <= fill_q + 2'(push) - 2'(cmd_pop_i);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ioc_back.sv =====
// Back engine: owns the ring pointers and the entry memories, executes one
// queued item at a time and registers its result. Depends on ioc_pkg, ioc_ram.
`default_nettype none

module ioc_back #(
  parameter int unsigned DEPTH = 256,
  localparam int unsigned IW   = $clog2(DEPTH),
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  input  ioc_pkg::ioc_cmd_t     cmd_i,
  output logic                  cmd_pop_o,
  output logic                  res_valid_o,
  output ioc_pkg::ioc_result_t  res_o
);

  ioc_pkg::ioc_back_state_e state_q, state_d;

  logic [IW-1:0]             head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]             inflight_q, inflight_d, cnt_q, cnt_d;
  logic [ioc_pkg::PTR_W-1:0] last_q, last_d;
  logic                      res_valid_d;
  ioc_pkg::ioc_result_t      res_d;

  logic                      ptr_we, done_we, done_wdata, done_rd, retire;
  logic [IW-1:0]             waddr, slot_idx, head_next, tail_next;
  logic [ioc_pkg::PTR_W-1:0] ptr_rd;
  logic [31:0]               slot_w, tail_w, cnt_w;
  logic                      is_full;

  assign slot_w    = 32'(cmd_i.slot);
  assign slot_idx  = slot_w[IW-1:0];
  assign tail_w    = 32'(tail_q);
  assign cnt_w     = 32'(cnt_q);
  assign head_next = (head_q == IW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign tail_next = (tail_q == IW'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
  assign is_full   = (inflight_q == CW'(DEPTH));
  assign retire    = (inflight_q != '0) && done_rd;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ioc_pkg::BK_IDLE: begin
        if (cmd_valid_i && cmd_i.op == ioc_pkg::OP_CONSUME) begin
          state_d = ioc_pkg::BK_WALK;
        end
      end
      ioc_pkg::BK_WALK: begin
        if (!retire) begin
          state_d = ioc_pkg::BK_IDLE;
        end
      end
      default: state_d = ioc_pkg::BK_IDLE;
    endcase
  end

  // Datapath control, memory writes and result formation.
  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    inflight_d  = inflight_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    cmd_pop_o   = 1'b0;
    ptr_we      = 1'b0;
    done_we     = 1'b0;
    done_wdata  = 1'b0;
    waddr       = tail_q;
    res_valid_d = 1'b0;
    res_d       = '0;
    unique case (state_q)
      ioc_pkg::BK_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.op)
            ioc_pkg::OP_ADD: begin
              res_valid_d = 1'b1;
              if (is_full) begin
                res_d.status = 1'b1;
              end else begin
                ptr_we           = 1'b1;
                done_we          = 1'b1;
                res_d.slot_index = tail_w[ioc_pkg::SLOT_W-1:0];
                tail_d           = tail_next;
                inflight_d       = inflight_q + 1'b1;
              end
            end
            ioc_pkg::OP_RELEASE: begin
              done_we     = 1'b1;
              done_wdata  = 1'b1;
              waddr       = slot_idx;
              res_valid_d = 1'b1;
            end
            ioc_pkg::OP_CONSUME: begin
              cnt_d = '0;
            end
            default: res_valid_d = 1'b1;
          endcase
        end
      end
      ioc_pkg::BK_WALK: begin
        if (retire) begin
          head_d     = head_next;
          inflight_d = inflight_q - 1'b1;
          cnt_d      = cnt_q + 1'b1;
          last_d     = ptr_rd;
        end else begin
          res_valid_d = 1'b1;
          if (cnt_q != '0) begin
            res_d.retired_any   = 1'b1;
            res_d.max_pointer   = last_q;
            res_d.retired_count = cnt_w[ioc_pkg::COUNT_W-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  // End pointer store; it is read every cycle at the next head.
  ioc_ram #(
    .WIDTH(ioc_pkg::PTR_W),
    .DEPTH(DEPTH)
  ) u_ptr_ram (
    .clk_i  (clk_i),
    .we_i   (ptr_we),
    .waddr_i(waddr),
    .wdata_i(cmd_i.end_pointer),
    .raddr_i(head_d),
    .rdata_o(ptr_rd)
  );

  // Done mark store; an add clears the mark, a release sets it.
  ioc_ram #(
    .WIDTH(1),
    .DEPTH(DEPTH)
  ) u_done_ram (
    .clk_i  (clk_i),
    .we_i   (done_we),
    .waddr_i(waddr),
    .wdata_i(done_wdata),
    .raddr_i(head_d),
    .rdata_o(done_rd)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ioc_pkg::BK_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      inflight_q  <= '0;
      cnt_q       <= '0;
      res_valid_o <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      inflight_q  <= inflight_d;
      cnt_q       <= cnt_d;
      res_valid_o <= res_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    last_q <= last_d;
    res_o  <= res_d;
  end

endmodule

`default_nettype wire

// ===== rtl/core/in_order_completion_ring.sv =====
// In-order completion ring. An add, release or no-op item gives a
// registered result strobe once the back engine takes it; a consume walks
// the ring, one entry per cycle, then gives its strobe. Outside a walk,
// the back engine executes one add or release per cycle; busy rises when
// the two-entry item queue is full. The receiver cannot stall results.
// Reset clears the pointers, the in-flight count and the queue.
`default_nettype none

module in_order_completion_ring #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    kind_i,
  input  logic [ioc_pkg::PTR_W-1:0]     end_pointer_i,
  input  logic [ioc_pkg::SLOT_W-1:0]    slot_i,
  output logic                          result_valid_o,
  output logic                          status_o,
  output logic [ioc_pkg::SLOT_W-1:0]    slot_index_o,
  output logic                          retired_any_o,
  output logic [ioc_pkg::PTR_W-1:0]     max_pointer_o,
  output logic [ioc_pkg::COUNT_W-1:0]   retired_count_o
);

  logic                 cmd_valid, cmd_pop;
  ioc_pkg::ioc_cmd_t    cmd;
  ioc_pkg::ioc_result_t res;

  // Front end with the item queue.
  ioc_front #(
    .DEPTH(DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .kind_i       (kind_i),
    .end_pointer_i(end_pointer_i),
    .slot_i       (slot_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  // Back engine with the ring state.
  ioc_back #(
    .DEPTH(DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .res_valid_o(result_valid_o),
    .res_o      (res)
  );

  assign status_o        = res.status;
  assign slot_index_o    = res.slot_index;
  assign retired_any_o   = res.retired_any;
  assign max_pointer_o   = res.max_pointer;
  assign retired_count_o = res.retired_count;

endmodule

`default_nettype wire
